// ===== sv/bpc_pkg.sv =====
// Shared types, codes and constants for the button press classifier.
package bpc_pkg;

  localparam int TIME_BITS   = 32;
  localparam int NUM_BUTTONS = 3;
  localparam int CFG_BITS    = 16;
  localparam int SEL_BITS    = 2;

  typedef logic [TIME_BITS-1:0] time_t;
  typedef logic [CFG_BITS-1:0]  cfg_word_t;
  typedef logic [SEL_BITS-1:0]  btn_sel_t;
  typedef logic [1:0]           tally_t;

  localparam tally_t TALLY_MAX         = 2'd3;
  localparam tally_t DOUBLE_MIN_CLICKS = 2'd2;

  localparam btn_sel_t BTN_LEFT   = 2'd0;
  localparam btn_sel_t BTN_RIGHT  = 2'd1;
  localparam btn_sel_t BTN_MIDDLE = 2'd2;

  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_SHORT  = 2'd1,
    EV_LONG   = 2'd2,
    EV_DOUBLE = 2'd3
  } event_t;

  typedef enum logic {
    CMD_UPDATE = 1'b0,
    CMD_READ   = 1'b1
  } cmd_t;

  localparam logic [1:0] CFG_DEBOUNCE      = 2'd0;
  localparam logic [1:0] CFG_LONG_PRESS    = 2'd1;
  localparam logic [1:0] CFG_DOUBLE_WINDOW = 2'd2;

  localparam cfg_word_t DEBOUNCE_RST      = 16'd50;
  localparam cfg_word_t LONG_PRESS_RST    = 16'd1000;
  localparam cfg_word_t DOUBLE_WINDOW_RST = 16'd300;

  typedef struct packed {
    cfg_word_t debounce;
    cfg_word_t hold_limit;
    cfg_word_t window;
  } cfg_t;

  typedef struct packed {
    logic upd;
    logic clr;
    logic level;
  } btn_ctl_t;

endpackage

// ===== sv/bpc_button.sv =====
// Per-button debounce, long press detection and click resolution.
module bpc_button (
  input  logic              clk,
  input  logic              rst_n,
  input  bpc_pkg::cfg_t     cfg,
  input  bpc_pkg::time_t    now,
  input  bpc_pkg::btn_ctl_t ctl,
  output bpc_pkg::event_t   pending_event
);
  import bpc_pkg::*;

  logic   prev_level_r, prev_level_nxt;
  time_t  level_change_time_r, level_change_time_nxt;
  logic   held_r, held_nxt;
  time_t  hold_start_time_r, hold_start_time_nxt;
  logic   long_done_r, long_done_nxt;
  tally_t click_tally_r, click_tally_nxt;
  time_t  release_time_r, release_time_nxt;
  event_t pending_event_r, pending_event_nxt;

  logic   lvl_chg, stable, down, press_start, long_fire, rel, click, resolve;
  time_t  el_change, el_hold, el_release;
  logic   long_done1;
  event_t pend2;
  tally_t tally2, tally3;
  time_t  rel_time3;

  always_comb begin
    lvl_chg     = (ctl.level != prev_level_r);
    el_change   = now - level_change_time_r;
    stable      = lvl_chg ? (cfg.debounce == '0) : (el_change >= time_t'(cfg.debounce));
    down        = !ctl.level;
    press_start = down && !held_r;

    el_hold    = press_start ? '0 : (now - hold_start_time_r);
    long_done1 = press_start ? 1'b0 : long_done_r;
    long_fire  = down && !long_done1 && (el_hold >= time_t'(cfg.hold_limit));
    pend2      = long_fire ? EV_LONG : pending_event_r;
    tally2     = long_fire ? '0 : click_tally_r;

    rel       = !down && held_r;
    click     = rel && !long_done_r;
    tally3    = (click && tally2 != TALLY_MAX) ? tally2 + 2'd1 : tally2;
    rel_time3 = click ? now : release_time_r;

    el_release = click ? '0 : (now - release_time_r);
    resolve    = (tally3 != '0) && !down && (el_release >= time_t'(cfg.window));

    prev_level_nxt        = prev_level_r;
    level_change_time_nxt = level_change_time_r;
    held_nxt              = held_r;
    hold_start_time_nxt   = hold_start_time_r;
    long_done_nxt         = long_done_r;
    click_tally_nxt       = click_tally_r;
    release_time_nxt      = release_time_r;
    pending_event_nxt     = pending_event_r;

    if (ctl.upd) begin
      prev_level_nxt = ctl.level;
      if (lvl_chg) begin
        level_change_time_nxt = now;
      end
      if (stable) begin
        held_nxt            = down;
        hold_start_time_nxt = press_start ? now : hold_start_time_r;
        long_done_nxt       = long_done1 | long_fire;
        release_time_nxt    = rel_time3;
        if (resolve) begin
          click_tally_nxt   = '0;
          pending_event_nxt = (tally3 >= DOUBLE_MIN_CLICKS) ? EV_DOUBLE : EV_SHORT;
        end else begin
          click_tally_nxt   = tally3;
          pending_event_nxt = pend2;
        end
      end
    end else if (ctl.clr) begin
      pending_event_nxt = EV_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_level_r        <= 1'b1;
      level_change_time_r <= '0;
      held_r              <= 1'b0;
      hold_start_time_r   <= '0;
      long_done_r         <= 1'b0;
      click_tally_r       <= '0;
      release_time_r      <= '0;
      pending_event_r     <= EV_NONE;
    end else begin
      prev_level_r        <= prev_level_nxt;
      level_change_time_r <= level_change_time_nxt;
      held_r              <= held_nxt;
      hold_start_time_r   <= hold_start_time_nxt;
      long_done_r         <= long_done_nxt;
      click_tally_r       <= click_tally_nxt;
      release_time_r      <= release_time_nxt;
      pending_event_r     <= pending_event_nxt;
    end
  end

  assign pending_event = pending_event_r;

  a_long_fire_sets_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.upd && stable && long_fire && !resolve) |=> (pending_event_r == EV_LONG))
    else $error("long press did not post");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.clr && !ctl.upd) |=> (pending_event_r == EV_NONE))
    else $error("read did not clear pending event");

  a_unstable_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.upd && !stable) |=>
      (held_r == $past(held_r)) && (click_tally_r == $past(click_tally_r)))
    else $error("press state moved while level not debounced");

endmodule

// ===== sv/button_press_classifier.sv =====
// Top level: input stage, three button units, result register and config registers.
// A read is registered in the input stage and then in the result register.
// Throughput: one item per cycle while no read waits; updates give no result and never wait on the output.
// A read waits in the input stage only while the result register is full and not taken.
// Synchronous active-low reset clears all button state, empties both stages and
// loads debounce 50, long press 1000 and double-click window 300.
module button_press_classifier (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      in_command,
  input  logic                      in_level_left,
  input  logic                      in_level_right,
  input  logic                      in_level_middle,
  input  logic [31:0]               in_now_ms,
  input  bpc_pkg::btn_sel_t         in_button_select,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [1:0]                out_event_code,
  output bpc_pkg::btn_sel_t         out_event_button,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [1:0]                cfg_index,
  input  bpc_pkg::cfg_word_t        cfg_data
);
  import bpc_pkg::*;

  logic                   s1_valid_r;
  cmd_t                   s1_cmd_r;
  logic [NUM_BUTTONS-1:0] s1_level_r;
  time_t                  s1_now_r;
  btn_sel_t               s1_sel_r;
  logic                   s1_go, in_xfer;

  logic     out_valid_r, out_valid_nxt, out_load;
  event_t   out_code_r, read_code;
  btn_sel_t out_button_r;

  cfg_t     cfg_r;
  btn_ctl_t ctl [NUM_BUTTONS];
  event_t   pend [NUM_BUTTONS];

  assign s1_go    = s1_valid_r && ((s1_cmd_r == CMD_UPDATE) || !out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_go;
  assign in_xfer  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_cmd_r   <= cmd_t'(in_command);
      s1_level_r <= {in_level_middle, in_level_right, in_level_left};
      s1_now_r   <= time_t'(in_now_ms);
      s1_sel_r   <= in_button_select;
    end
  end

  genvar gi;
  generate
    for (gi = 0; gi < NUM_BUTTONS; gi++) begin : g_btn
      always_comb begin
        ctl[gi].upd   = s1_go && (s1_cmd_r == CMD_UPDATE);
        ctl[gi].clr   = s1_go && (s1_cmd_r == CMD_READ) && (s1_sel_r == btn_sel_t'(gi));
        ctl[gi].level = s1_level_r[gi];
      end

      bpc_button u_button (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_r),
        .now           (s1_now_r),
        .ctl           (ctl[gi]),
        .pending_event (pend[gi])
      );
    end
  endgenerate

  always_comb begin
    case (s1_sel_r)
      BTN_LEFT:   read_code = pend[0];
      BTN_RIGHT:  read_code = pend[1];
      BTN_MIDDLE: read_code = pend[2];
      default:    read_code = EV_NONE;
    endcase
  end

  assign out_load      = s1_go && (s1_cmd_r == CMD_READ);
  assign out_valid_nxt = (out_valid_r && !out_ready) || out_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_code_r   <= read_code;
      out_button_r <= s1_sel_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_event_code   = out_code_r;
  assign out_event_button = out_button_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce   <= DEBOUNCE_RST;
      cfg_r.hold_limit <= LONG_PRESS_RST;
      cfg_r.window     <= DOUBLE_WINDOW_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_DEBOUNCE:      cfg_r.debounce   <= cfg_data;
        CFG_LONG_PRESS:    cfg_r.hold_limit <= cfg_data;
        CFG_DOUBLE_WINDOW: cfg_r.window     <= cfg_data;
        default:           cfg_r            <= cfg_r;
      endcase
    end
  end

  a_read_posts_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> out_valid_r)
    else $error("read transfer produced no result");

  a_update_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_load && !out_valid_r) |=> !out_valid_r)
    else $error("result appeared without a read");

  a_read_waits_for_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && (s1_cmd_r == CMD_READ) && out_valid_r && !out_ready) |-> !s1_go)
    else $error("read advanced into a full result register");

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for button_press_classifier: random press gestures, reads and settings.
module testbench;
  import bpc_pkg::*;

  localparam btn_sel_t BTN_NONE = 2'd3;

  typedef struct {
    cmd_t        cmd;
    logic [2:0]  lvls;
    time_t       now;
    btn_sel_t    sel;
  } btn_item_t;

  typedef struct {
    event_t   code;
    btn_sel_t btn;
  } read_result_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic              in_command = 1'b0;
  logic              in_level_left = 1'b1;
  logic              in_level_right = 1'b1;
  logic              in_level_middle = 1'b1;
  logic [31:0]       in_now_ms = '0;
  btn_sel_t          in_button_select = BTN_LEFT;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [1:0]        out_event_code;
  btn_sel_t          out_event_button;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [1:0]        cfg_index = CFG_DEBOUNCE;
  cfg_word_t         cfg_data = '0;

  button_press_classifier u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_command       (in_command),
    .in_level_left    (in_level_left),
    .in_level_right   (in_level_right),
    .in_level_middle  (in_level_middle),
    .in_now_ms        (in_now_ms),
    .in_button_select (in_button_select),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_event_code   (out_event_code),
    .out_event_button (out_event_button),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // classifier state mirrored per button
  logic      seen_lvl    [NUM_BUTTONS];
  time_t     lvl_since   [NUM_BUTTONS];
  logic      is_held     [NUM_BUTTONS];
  time_t     held_since  [NUM_BUTTONS];
  logic      long_fired  [NUM_BUTTONS];
  tally_t    click_cnt   [NUM_BUTTONS];
  time_t     released_at [NUM_BUTTONS];
  event_t    pending_ev  [NUM_BUTTONS];
  cfg_word_t db_ms  = DEBOUNCE_RST;
  cfg_word_t lp_ms  = LONG_PRESS_RST;
  cfg_word_t win_ms = DOUBLE_WINDOW_RST;

  btn_item_t    pending_items[$];
  read_result_t awaited_events[$];
  btn_item_t    cur;
  read_result_t want;

  int          errors = 0;
  int          n_updates = 0;
  int          n_reads = 0;
  int          n_checked = 0;
  int          n_settings = 0;
  int          queued_n = 0;
  int          burst_left = 0;
  int          gap_left = 0;
  int          roll_left = 0;
  logic [15:0] stall_pat = '1;
  time_t       clock_ms = '0;
  logic [2:0]  pin_lvls = 3'b111;
  cfg_t        plan [7];

  function automatic void advance_button(int b, logic lvl, time_t now);
    logic down;
    if (lvl != seen_lvl[b])
      lvl_since[b] = now;
    seen_lvl[b] = lvl;
    if (time_t'(now - lvl_since[b]) < db_ms)
      return;
    down = !lvl;
    if (down && !is_held[b]) begin
      is_held[b]    = 1'b1;
      held_since[b] = now;
      long_fired[b] = 1'b0;
    end
    if (down && is_held[b] && !long_fired[b]) begin
      if (time_t'(now - held_since[b]) >= lp_ms) begin
        pending_ev[b] = EV_LONG;
        long_fired[b] = 1'b1;
        click_cnt[b]  = '0;
      end
    end
    if (!down && is_held[b]) begin
      is_held[b] = 1'b0;
      if (!long_fired[b]) begin
        if (click_cnt[b] < TALLY_MAX)
          click_cnt[b] = click_cnt[b] + 1'b1;
        released_at[b] = now;
      end
    end
    if (click_cnt[b] != 0 && !is_held[b] && time_t'(now - released_at[b]) >= win_ms) begin
      pending_ev[b] = (click_cnt[b] >= DOUBLE_MIN_CLICKS) ? EV_DOUBLE : EV_SHORT;
      click_cnt[b]  = '0;
    end
  endfunction

  function automatic void take_event(btn_sel_t sel);
    read_result_t r;
    r.code = EV_NONE;
    r.btn  = sel;
    if (sel < NUM_BUTTONS) begin
      r.code          = pending_ev[sel];
      pending_ev[sel] = EV_NONE;
    end
    awaited_events.push_back(r);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        if (cur.cmd == CMD_UPDATE) begin
          for (int b = 0; b < NUM_BUTTONS; b++)
            advance_button(b, cur.lvls[b], cur.now);
          n_updates++;
        end else begin
          take_event(cur.sel);
          n_reads++;
        end
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_items.size() != 0) begin
          cur = pending_items.pop_front();
          in_command       <= cur.cmd;
          in_level_left    <= cur.lvls[BTN_LEFT];
          in_level_right   <= cur.lvls[BTN_RIGHT];
          in_level_middle  <= cur.lvls[BTN_MIDDLE];
          in_now_ms        <= cur.now;
          in_button_select <= cur.sel;
          in_valid         <= 1'b1;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (awaited_events.size() == 0) begin
          errors++;
          $display("%0t: unexpected result: code %0d button %0d", $time,
                   out_event_code, out_event_button);
        end else begin
          want = awaited_events.pop_front();
          n_checked++;
          if (out_event_code !== want.code) begin
            errors++;
            $display("%0t: event_code expected %0d actual %0d", $time, want.code,
                     out_event_code);
          end
          if (out_event_button !== want.btn) begin
            errors++;
            $display("%0t: event_button expected %0d actual %0d", $time, want.btn,
                     out_event_button);
          end
        end
      end
      if (roll_left == 0) begin
        roll_left = 50;
        stall_pat = ($urandom_range(0, 2) == 0) ? 16'hFFFF : (16'($urandom) | 16'd1);
      end else begin
        roll_left--;
      end
      out_ready <= stall_pat[0];
      stall_pat = {stall_pat[0], stall_pat[15:1]};
    end
  end

  task automatic add_update(input int unsigned dt);
    btn_item_t it;
    clock_ms += time_t'(dt);
    it.cmd  = CMD_UPDATE;
    it.lvls = pin_lvls;
    it.now  = clock_ms;
    it.sel  = btn_sel_t'($urandom_range(0, 3));
    pending_items.push_back(it);
    queued_n++;
  endtask

  task automatic add_read(input btn_sel_t sel);
    btn_item_t it;
    it.cmd  = CMD_READ;
    it.lvls = 3'($urandom);
    it.now  = time_t'($urandom);
    it.sel  = sel;
    pending_items.push_back(it);
    queued_n++;
  endtask

  function automatic int unsigned at_least(int unsigned base);
    case ($urandom_range(0, 3))
      0:       return base;
      1:       return base + 1;
      default: return base + $urandom_range(2, 40);
    endcase
  endfunction

  function automatic int unsigned short_of(int unsigned base);
    return (base == 0) ? 0 : $urandom_range(0, base - 1);
  endfunction

  task automatic add_gesture();
    logic [2:0] mask;
    int         taps;
    bit         go_long;
    mask    = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(1, 7))
                                          : 3'(1 << $urandom_range(0, 2));
    taps    = $urandom_range(1, 4);
    go_long = ($urandom_range(0, 3) == 0);
    for (int k = 0; k < taps; k++) begin
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 3)) begin
          pin_lvls ^= mask;
          add_update(short_of(db_ms));
        end
      end
      pin_lvls &= ~mask;
      add_update($urandom_range(1, 200));
      add_update(at_least(db_ms));
      if (go_long && k == taps - 1)
        add_update(($urandom_range(0, 3) == 0) ? short_of(lp_ms) : at_least(lp_ms));
      pin_lvls |= mask;
      add_update($urandom_range(1, 200));
      add_update(at_least(db_ms));
      if (k < taps - 1 && $urandom_range(0, 2) == 0)
        add_update(short_of(win_ms));
    end
    add_update(($urandom_range(0, 3) == 0) ? short_of(win_ms) : at_least(win_ms));
    for (int b = 0; b < NUM_BUTTONS; b++)
      if (mask[b] || $urandom_range(0, 3) == 0)
        add_read(btn_sel_t'(b));
  endtask

  task automatic write_reg(input logic [1:0] idx, input cfg_word_t val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    cfg_valid <= 1'b0;
    case (idx)
      CFG_DEBOUNCE:      db_ms  = val;
      CFG_LONG_PRESS:    lp_ms  = val;
      CFG_DOUBLE_WINDOW: win_ms = val;
      default: ;
    endcase
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    while (pending_items.size() != 0 || in_valid)
      @(posedge clk);
    while (awaited_events.size() != 0 && guard < 2000) begin
      @(posedge clk);
      guard++;
    end
    if (awaited_events.size() != 0) begin
      errors++;
      $display("%0t: %0d results never arrived, next expected code %0d button %0d", $time,
               awaited_events.size(), awaited_events[0].code, awaited_events[0].btn);
      awaited_events.delete();
    end
    repeat (4) @(posedge clk);
  endtask

  initial begin
    for (int b = 0; b < NUM_BUTTONS; b++) begin
      seen_lvl[b]    = 1'b1;
      lvl_since[b]   = '0;
      is_held[b]     = 1'b0;
      held_since[b]  = '0;
      long_fired[b]  = 1'b0;
      click_cnt[b]   = '0;
      released_at[b] = '0;
      pending_ev[b]  = EV_NONE;
    end
    plan[0] = '{debounce: 16'd0,     hold_limit: 16'd0,     window: 16'd0};
    plan[1] = '{debounce: 16'd65535, hold_limit: 16'd65535, window: 16'd65535};
    plan[2] = '{debounce: 16'd10,    hold_limit: 16'd0,     window: 16'd40};
    plan[3] = '{debounce: 16'($urandom_range(0, 100)), hold_limit: 16'($urandom_range(0, 600)),
                window: 16'($urandom_range(0, 300))};
    plan[4] = '{debounce: 16'd0,     hold_limit: 16'd65535, window: 16'd1};
    plan[5] = '{debounce: 16'd65535, hold_limit: 16'd1,     window: 16'd0};
    plan[6] = '{debounce: DEBOUNCE_RST, hold_limit: LONG_PRESS_RST, window: DOUBLE_WINDOW_RST};

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    add_read(BTN_LEFT);
    add_read(BTN_RIGHT);
    add_read(BTN_MIDDLE);
    add_read(BTN_NONE);
    add_update(100);
    pin_lvls[BTN_LEFT] = 1'b0;
    add_update(100);
    add_update(60);
    pin_lvls[BTN_LEFT] = 1'b1;
    add_update(40);
    add_update(60);
    add_update(340);
    add_read(BTN_LEFT);
    add_read(BTN_LEFT);
    pin_lvls[BTN_RIGHT] = 1'b0;
    add_update(100);
    add_update(60);
    add_update(1040);
    add_read(BTN_RIGHT);
    pin_lvls[BTN_RIGHT]  = 1'b1;
    pin_lvls[BTN_MIDDLE] = 1'b0;
    add_update(100);
    add_update(60);
    pin_lvls[BTN_MIDDLE] = 1'b1;
    add_update(20);
    add_update(60);
    pin_lvls[BTN_MIDDLE] = 1'b0;
    add_update(20);
    add_update(60);
    pin_lvls[BTN_MIDDLE] = 1'b1;
    add_update(20);
    add_update(60);
    add_update(300);
    add_read(BTN_MIDDLE);
    drain();

    for (int p = 0; p < 7; p++) begin
      write_reg(CFG_DEBOUNCE, plan[p].debounce);
      write_reg(CFG_LONG_PRESS, plan[p].hold_limit);
      write_reg(CFG_DOUBLE_WINDOW, plan[p].window);
      n_settings++;
      if (p == 1 || p == 3 || p == 4)
        clock_ms = '1 - time_t'($urandom_range(0, 200000));
      queued_n = 0;
      while (queued_n < 62) begin
        case ($urandom_range(0, 9))
          0: begin
            pin_lvls = 3'($urandom);
            add_update(($urandom_range(0, 2) == 0) ? $urandom : $urandom_range(0, 2 * db_ms + 10));
          end
          1: add_read(btn_sel_t'($urandom_range(0, 3)));
          default: add_gesture();
        endcase
      end
      drain();
    end

    $display("summary: %0d updates and %0d reads transferred, %0d results checked, %0d settings",
             n_updates, n_reads, n_checked, n_settings + 1);
    if (errors == 0)
      $display("testbench: done, clean");
    else
      $display("testbench: done, errors");
    $finish;
  end

  initial begin
    #3600000;
    $display("testbench: done, errors");
    $finish;
  end

endmodule
